/* design/qlte_pkg.sv */
`timescale 1ns / 1ps

package qlte_pkg;

  // Fixed field widths of the stream items
  localparam int OP_W     = 1;
  localparam int SIDX_W   = 9;
  localparam int ACT_W    = 3;
  localparam int REWARD_W = 24;
  localparam int RATE_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int NEWV_W   = 24;
  localparam int COEF_W   = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  // Operation codes carried on s_tuser
  localparam logic [OP_W-1:0] OP_SELECT = 1'b0;
  localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DISCOUNT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXPLORE_FLOOR = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_EXPLORE_DECAY = 2'd3;

  // Reset values
  localparam logic [COEF_W-1:0]  LEARNING_RATE_RST = 16'd9830;
  localparam logic [COEF_W-1:0]  DISCOUNT_RST      = 16'd58982;
  localparam logic [COEF_W-1:0]  EXPLORE_FLOOR_RST = 16'd3277;
  localparam logic [COEF_W-1:0]  EXPLORE_DECAY_RST = 16'd65470;
  localparam logic [RATE_W-1:0]  EXPLORE_LEVEL_RST = 16'd26214;
  localparam int                 VALUE_RST         = 128;

  // Half an LSB of a Q0.16 product, for round half up
  localparam int ROUND_HALF = 32768;
  localparam int Q_SHIFT    = 16;

  // Input item, state_index in the lowest bits
  typedef struct packed {
    logic [ACT_W-1:0]    explore_action;
    logic [RATE_W-1:0]   explore_draw;
    logic [SIDX_W-1:0]   next_state_index;
    logic [REWARD_W-1:0] reward;
    logic [ACT_W-1:0]    action_taken;
    logic [SIDX_W-1:0]   state_index;
  } in_item_t;

  // Result item, chosen_action in the lowest bits, padded to whole bytes
  typedef struct packed {
    logic [2:0]          pad;
    logic [COUNT_W-1:0]  update_count;
    logic [RATE_W-1:0]   explore_rate;
    logic                saturated;
    logic [NEWV_W-1:0]   new_value;
    logic                explored;
    logic [ACT_W-1:0]    chosen_action;
  } out_item_t;

endpackage

/* design/qlte_row_ram.sv */
`timescale 1ns / 1ps

module qlte_row_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* design/q_learning_table_engine.sv */
`timescale 1ns / 1ps
// Sequence: a select passes the read and hold states, an update the read, scale, diff, corr,
// write and hold states; hold waits while an earlier result is untaken. Throughput: one item
// at a time, set by the read-modify-write sequence over the row memory and its two multiplier
// steps. Reset: synchronous; config, exploration rate and counter return to their defaults,
// then a clearing pass writes every table row to 128; s_tready is low meanwhile.
module q_learning_table_engine #(
  parameter int STATE_COUNT  = 512,
  parameter int ACTION_COUNT = 5,
  parameter int VALUE_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [qlte_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [qlte_pkg::COEF_W-1:0]         cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: state_index, action_taken, reward, next_state_index, explore_draw,
  //          explore_action
  input  logic [qlte_pkg::IN_DATA_W-1:0]      s_tdata,
  // s_tuser: operation
  input  logic [qlte_pkg::OP_W-1:0]           s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: chosen_action, explored, new_value, saturated, explore_rate, update_count,
  //          zero padding
  output logic [qlte_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int RW    = $clog2(STATE_COUNT);
  localparam int AIW   = $clog2(ACTION_COUNT);
  localparam int VW    = VALUE_WIDTH;
  localparam int ROW_W = ACTION_COUNT * VW;
  localparam int PGW   = VW + qlte_pkg::COEF_W + 1;          // gamma * maxq
  localparam int GW    = PGW + 1 - qlte_pkg::Q_SHIFT;        // rounded gamma term
  localparam int DW    = ((GW > qlte_pkg::REWARD_W) ? GW : qlte_pkg::REWARD_W) + 2;
  localparam int PAW   = DW + qlte_pkg::COEF_W + 1;          // alpha * diff
  localparam int AW    = PAW + 1 - qlte_pkg::Q_SHIFT;        // rounded correction
  localparam int NW    = AW + 1;
  localparam int SIDX_SPAN = 1 << qlte_pkg::SIDX_W;

  localparam logic signed [NW-1:0] V_MAX = NW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [NW-1:0] V_MIN = -V_MAX - NW'(1);
  localparam logic signed [VW-1:0] V_INIT = VW'(qlte_pkg::VALUE_RST);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SCALE, S_DIFF, S_CORR, S_WRITE, S_HOLD
  } state_t;

  state_t state;

  // reduce a state index into the table, one compare and subtract per bit
  function automatic logic [RW-1:0] row_of(input logic [qlte_pkg::SIDX_W-1:0] idx);
    logic [qlte_pkg::SIDX_W:0] x;
    x = {1'b0, idx};
    for (int k = qlte_pkg::SIDX_W - 1; k >= 0; k--) begin
      if ((STATE_COUNT << k) < SIDX_SPAN && x >= (qlte_pkg::SIDX_W + 1)'(STATE_COUNT << k)) begin
        x = x - (qlte_pkg::SIDX_W + 1)'(STATE_COUNT << k);
      end
    end
    return RW'(x);
  endfunction

  function automatic logic [AIW-1:0] clamp_action(input logic [qlte_pkg::ACT_W-1:0] a);
    logic [AIW-1:0] r;
    if (32'(a) >= ACTION_COUNT) begin
      r = AIW'(ACTION_COUNT - 1);
    end else begin
      r = AIW'(a);
    end
    return r;
  endfunction

  qlte_pkg::in_item_t  in_item;
  qlte_pkg::out_item_t res;

  // config registers
  logic [qlte_pkg::COEF_W-1:0] learning_rate;
  logic [qlte_pkg::COEF_W-1:0] discount;
  logic [qlte_pkg::COEF_W-1:0] explore_floor;
  logic [qlte_pkg::COEF_W-1:0] explore_decay;

  logic [qlte_pkg::RATE_W-1:0]  explore_level;
  logic [qlte_pkg::RATE_W-1:0]  explore_level_next;
  logic [qlte_pkg::COUNT_W-1:0] update_counter;
  logic [RW-1:0]                clear_idx;

  // captured item
  logic [qlte_pkg::OP_W-1:0]          op;
  logic [AIW-1:0]                     act;
  logic [AIW-1:0]                     xact;
  logic [qlte_pkg::RATE_W-1:0]        draw;
  logic [RW-1:0]                      row;
  logic signed [qlte_pkg::REWARD_W-1:0] reward;

  // datapath registers
  logic signed [VW-1:0]  maxq;
  logic signed [VW-1:0]  cur;
  logic signed [PGW-1:0] prod_g;
  logic signed [DW-1:0]  diff;
  logic signed [PAW-1:0] prod_a;

  // memory ports
  logic             ram_we;
  logic [RW-1:0]    ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_re;
  logic [ROW_W-1:0] row_a;
  logic [ROW_W-1:0] row_b;
  logic [ROW_W-1:0] init_row;
  logic [ROW_W-1:0] upd_row;

  logic [ROW_W-1:0]       row_sel;
  logic [AIW-1:0]         best_idx;
  logic signed [VW-1:0]   best_val;
  logic signed [VW-1:0]   cur_val;

  logic signed [GW-1:0]   g_round;
  logic signed [PGW:0]    g_sum;
  logic signed [DW-1:0]   diff_next;
  logic signed [PAW:0]    a_sum;
  logic signed [AW-1:0]   a_round;
  logic signed [NW-1:0]   nv;
  logic signed [NW-1:0]   nv_sat;
  logic                   nv_clip;
  logic [31:0]            eps_prod;

  assign in_item  = qlte_pkg::in_item_t'(s_tdata);
  assign s_tready = (state == S_IDLE);
  assign ram_re   = s_tvalid && s_tready;

  qlte_row_ram #(
    .DEPTH (STATE_COUNT),
    .WIDTH (ROW_W)
  ) u_row_ram (
    .clk       (clk),
    .we        (ram_we),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .re        (ram_re),
    .rd_addr_a (row_of(in_item.state_index)),
    .rd_addr_b (row_of(in_item.next_state_index)),
    .rd_data_a (row_a),
    .rd_data_b (row_b)
  );

  // greedy search over the row, lowest index wins ties
  always_comb begin
    row_sel  = (op == qlte_pkg::OP_SELECT) ? row_a : row_b;
    best_idx = '0;
    best_val = $signed(row_sel[VW-1:0]);
    for (int a = 1; a < ACTION_COUNT; a++) begin
      if ($signed(row_sel[a*VW +: VW]) > best_val) begin
        best_val = $signed(row_sel[a*VW +: VW]);
        best_idx = AIW'(a);
      end
    end
    cur_val = $signed(row_a[act*VW +: VW]);
  end

  always_comb begin
    g_sum     = PGW'(prod_g) + (PGW + 1)'(qlte_pkg::ROUND_HALF);
    g_round   = g_sum[PGW:qlte_pkg::Q_SHIFT];
    diff_next = DW'(reward) + DW'(g_round) - DW'(cur);
    a_sum     = (PAW + 1)'(prod_a) + (PAW + 1)'(qlte_pkg::ROUND_HALF);
    a_round   = a_sum[PAW:qlte_pkg::Q_SHIFT];
    nv        = NW'(cur) + NW'(a_round);
    nv_clip   = 1'b0;
    nv_sat    = nv;
    if (nv > V_MAX) begin
      nv_sat  = V_MAX;
      nv_clip = 1'b1;
    end else if (nv < V_MIN) begin
      nv_sat  = V_MIN;
      nv_clip = 1'b1;
    end
  end

  // decay only while above the floor
  always_comb begin
    eps_prod = 32'(explore_level) * 32'(explore_decay);
    if (explore_level > explore_floor) begin
      explore_level_next = eps_prod[31:16];
    end else begin
      explore_level_next = explore_level;
    end
  end

  always_comb begin
    for (int a = 0; a < ACTION_COUNT; a++) begin
      init_row[a*VW +: VW] = V_INIT;
    end
    upd_row = row_a;
    upd_row[act*VW +: VW] = nv_sat[VW-1:0];
    if (state == S_CLEAR) begin
      ram_we      = 1'b1;
      ram_wr_addr = clear_idx;
      ram_wr_data = init_row;
    end else begin
      ram_we      = (state == S_WRITE);
      ram_wr_addr = row;
      ram_wr_data = upd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= qlte_pkg::LEARNING_RATE_RST;
      discount      <= qlte_pkg::DISCOUNT_RST;
      explore_floor <= qlte_pkg::EXPLORE_FLOOR_RST;
      explore_decay <= qlte_pkg::EXPLORE_DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qlte_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data;
        qlte_pkg::REG_DISCOUNT:      discount      <= cfg_data;
        qlte_pkg::REG_EXPLORE_FLOOR: explore_floor <= cfg_data;
        qlte_pkg::REG_EXPLORE_DECAY: explore_decay <= cfg_data;
        default: ;
      endcase
    end
  end

  // controller with state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_idx      <= '0;
      explore_level  <= qlte_pkg::EXPLORE_LEVEL_RST;
      update_counter <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // the hold state reloads valid itself
      if (m_tvalid && m_tready && state != S_HOLD) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clear_idx <= clear_idx + RW'(1);
          if (clear_idx == RW'(STATE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= (op == qlte_pkg::OP_SELECT) ? S_HOLD : S_SCALE;
        end
        S_SCALE: state <= S_DIFF;
        S_DIFF:  state <= S_CORR;
        S_CORR:  state <= S_WRITE;
        S_WRITE: begin
          explore_level  <= explore_level_next;
          update_counter <= update_counter + 32'd1;
          state          <= S_HOLD;
        end
        S_HOLD: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op     <= s_tuser;
        act    <= clamp_action(in_item.action_taken);
        xact   <= clamp_action(in_item.explore_action);
        draw   <= in_item.explore_draw;
        row    <= row_of(in_item.state_index);
        reward <= $signed(in_item.reward);
      end
      S_READ: begin
        maxq <= best_val;
        cur  <= cur_val;
        res.pad           <= '0;
        res.new_value     <= '0;
        res.saturated     <= 1'b0;
        res.explore_rate  <= explore_level;
        res.update_count  <= update_counter;
        if (draw < explore_level) begin
          res.chosen_action <= qlte_pkg::ACT_W'(xact);
          res.explored      <= 1'b1;
        end else begin
          res.chosen_action <= qlte_pkg::ACT_W'(best_idx);
          res.explored      <= 1'b0;
        end
      end
      S_SCALE: prod_g <= PGW'($signed({1'b0, discount})) * PGW'(maxq);
      S_DIFF:  diff   <= diff_next;
      S_CORR:  prod_a <= PAW'($signed({1'b0, learning_rate})) * PAW'(diff);
      S_WRITE: begin
        res.chosen_action <= '0;
        res.explored      <= 1'b0;
        res.new_value     <= nv_sat[qlte_pkg::NEWV_W-1:0];
        res.saturated     <= nv_clip;
        res.explore_rate  <= explore_level_next;
        res.update_count  <= update_counter + 32'd1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (update_counter == $past(update_counter) + 32'd1))
    else $error("update counter did not advance on write-back");

  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (explore_level <= $past(explore_level)))
    else $error("exploration rate increased");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_HOLD))
    else $error("result issued outside the hold state");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WRITE) && !s_tready)
    else $error("table written while accepting a transaction");

endmodule

/* dv/qlte_result_checker.sv */
`timescale 1ns / 1ps

module qlte_result_checker #(
  parameter int ROWS    = 512,
  parameter int ACTIONS = 5,
  parameter int VW      = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qlte_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [qlte_pkg::COEF_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [qlte_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [qlte_pkg::OP_W-1:0]           s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [qlte_pkg::OUT_DATA_W-1:0]     m_tdata,
  output int                                  mismatch_count,
  output int                                  results_owed
);

  import qlte_pkg::*;

  logic signed [VW-1:0] q_table [ROWS*ACTIONS];
  logic [COEF_W-1:0]    alpha;
  logic [COEF_W-1:0]    gamma;
  logic [COEF_W-1:0]    rate_floor;
  logic [COEF_W-1:0]    decay;
  logic [RATE_W-1:0]    explore_level;
  logic [COUNT_W-1:0]   updates_done;
  out_item_t            expected_results[$];
  int                   errors;

  function automatic logic [ACT_W-1:0] clamp_act(logic [ACT_W-1:0] a);
    return (int'(a) >= ACTIONS) ? ACT_W'(ACTIONS - 1) : a;
  endfunction

  // lowest index wins a tie
  function automatic logic [ACT_W-1:0] greedy_action(int row);
    logic [ACT_W-1:0] best = '0;
    for (int a = 1; a < ACTIONS; a++)
      if (q_table[row*ACTIONS + a] > q_table[row*ACTIONS + int'(best)]) best = ACT_W'(a);
    return best;
  endfunction

  // Q0.16 coefficient times value, round half up
  function automatic longint scale_round(logic [COEF_W-1:0] coef, longint v);
    return (longint'(coef) * v + ROUND_HALF) >>> Q_SHIFT;
  endfunction

  function automatic out_item_t apply_item(logic [OP_W-1:0] op, in_item_t it);
    out_item_t r;
    int        row;
    int        nrow;
    int        slot;
    longint    maxq;
    longint    cur;
    longint    diff;
    longint    nv;
    longint    hi;
    longint    lo;
    r    = '0;
    hi   = (longint'(1) << (VW - 1)) - 1;
    lo   = -hi - 1;
    row  = int'(it.state_index) % ROWS;
    if (op == OP_SELECT) begin
      if (it.explore_draw < explore_level) begin
        r.chosen_action = clamp_act(it.explore_action);
        r.explored      = 1'b1;
      end else begin
        r.chosen_action = greedy_action(row);
      end
    end else begin
      nrow = int'(it.next_state_index) % ROWS;
      slot = row*ACTIONS + int'(clamp_act(it.action_taken));
      maxq = q_table[nrow*ACTIONS + int'(greedy_action(nrow))];
      cur  = q_table[slot];
      diff = longint'($signed(it.reward)) + scale_round(gamma, maxq) - cur;
      nv   = cur + scale_round(alpha, diff);
      if (nv > hi) begin
        nv          = hi;
        r.saturated = 1'b1;
      end else if (nv < lo) begin
        nv          = lo;
        r.saturated = 1'b1;
      end
      q_table[slot] = nv[VW-1:0];
      r.new_value   = nv[NEWV_W-1:0];
      if (explore_level > rate_floor)
        explore_level = RATE_W'((32'(explore_level) * 32'(decay)) >> Q_SHIFT);
      updates_done = updates_done + 1;
    end
    r.explore_rate = explore_level;
    r.update_count = updates_done;
    return r;
  endfunction

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < ROWS*ACTIONS; i++) q_table[i] = VW'(VALUE_RST);
      alpha         = LEARNING_RATE_RST;
      gamma         = DISCOUNT_RST;
      rate_floor    = EXPLORE_FLOOR_RST;
      decay         = EXPLORE_DECAY_RST;
      explore_level = EXPLORE_LEVEL_RST;
      updates_done  = '0;
      errors        = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: alpha      = cfg_data;
          REG_DISCOUNT:      gamma      = cfg_data;
          REG_EXPLORE_FLOOR: rate_floor = cfg_data;
          REG_EXPLORE_DECAY: decay      = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_item(s_tuser, in_item_t'(s_tdata)));
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: result expected none, got 0x%0h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("chosen_action", 64'(want.chosen_action), 64'(got.chosen_action));
          compare_field("explored", 64'(want.explored), 64'(got.explored));
          compare_field("new_value", 64'(want.new_value), 64'(got.new_value));
          compare_field("saturated", 64'(want.saturated), 64'(got.saturated));
          compare_field("explore_rate", 64'(want.explore_rate), 64'(got.explore_rate));
          compare_field("update_count", 64'(want.update_count), 64'(got.update_count));
          compare_field("padding", 64'(want.pad), 64'(got.pad));
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= expected_results.size();
  end

endmodule

/* dv/tb_q_learning_table_engine.sv */
`timescale 1ns / 1ps

module tb_q_learning_table_engine;

  import qlte_pkg::*;

  localparam int IDLE_LIMIT       = 4000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE  = 280;
  localparam logic [REWARD_W-1:0] REWARD_MAX = {1'b0, {(REWARD_W-1){1'b1}}};
  localparam logic [REWARD_W-1:0] REWARD_MIN = {1'b1, {(REWARD_W-1){1'b0}}};
  localparam logic [RATE_W-1:0]   DRAW_MAX   = '1;
  localparam logic [COEF_W-1:0]   COEF_MAX   = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0]     cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatch_count;
  int results_owed;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  q_learning_table_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  qlte_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(int sidx, int act, logic [REWARD_W-1:0] rew,
                                         int nsidx, logic [RATE_W-1:0] draw, int xact);
    in_item_t it;
    it.state_index      = SIDX_W'(sidx);
    it.action_taken     = ACT_W'(act);
    it.reward           = rew;
    it.next_state_index = SIDX_W'(nsidx);
    it.explore_draw     = draw;
    it.explore_action   = ACT_W'(xact);
    return it;
  endfunction

  // keep most traffic on a few rows so the values there evolve
  function automatic int pick_row();
    case ($urandom_range(9))
      0:       return (1 << SIDX_W) - 1;
      1, 2:    return $urandom_range((1 << SIDX_W) - 1);
      default: return $urandom_range(5);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.state_index      = SIDX_W'(pick_row());
    it.next_state_index = SIDX_W'(pick_row());
    it.action_taken     = ACT_W'($urandom_range(7));
    it.explore_action   = ACT_W'($urandom_range(7));
    it.explore_draw     = ($urandom_range(9) < 3) ? RATE_W'($urandom_range(2047))
                                                  : RATE_W'($urandom_range(65535));
    case ($urandom_range(9))
      0:          it.reward = REWARD_MAX;
      1:          it.reward = REWARD_MIN;
      2, 3, 4, 5: it.reward = REWARD_W'(int'($urandom_range(4096)) - 2048);
      default:    it.reward = REWARD_W'($urandom());
    endcase
    return it;
  endfunction

  // valid stays high across back-to-back transactions; drop it only for a gap
  task automatic send_item(logic [OP_W-1:0] op, in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [COEF_W-1:0] lr, logic [COEF_W-1:0] disc,
                                logic [COEF_W-1:0] flr, logic [COEF_W-1:0] dec);
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_DISCOUNT, disc);
    write_reg(REG_EXPLORE_FLOOR, flr);
    write_reg(REG_EXPLORE_DECAY, dec);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, int idle_pct, int stall, bit pause_midway);
    logic [OP_W-1:0] op;
    send_idle_pct = idle_pct;
    stall_pct    <= stall;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain_results();
      op = ($urandom_range(1) == 1) ? OP_UPDATE : OP_SELECT;
      send_item(op, random_item());
    end
    drain_results();
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_LEARNING_RATE;
    cfg_data      <= '0;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tuser       <= OP_SELECT;
    m_tready      <= 1'b0;
    stall_pct     <= 0;
    send_idle_pct  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ties, the draw on either side of the rate, clamped actions
    send_item(OP_SELECT, make_item(0, 0, '0, 0, DRAW_MAX, 0));
    send_item(OP_SELECT, make_item(511, 0, '0, 0, EXPLORE_LEVEL_RST, 7));
    send_item(OP_SELECT, make_item(0, 0, '0, 0, RATE_W'(EXPLORE_LEVEL_RST - 1), 7));
    send_item(OP_SELECT, make_item(5, 0, '0, 0, '0, 3));
    send_item(OP_UPDATE, make_item(0, 2, REWARD_MAX, 511, '0, 0));
    send_item(OP_UPDATE, make_item(511, 7, REWARD_MIN, 0, '0, 0));
    send_item(OP_UPDATE, make_item(0, 5, '0, 0, DRAW_MAX, 7));
    send_item(OP_SELECT, make_item(0, 0, '0, 0, DRAW_MAX, 0));
    send_item(OP_SELECT, make_item(511, 0, '0, 0, DRAW_MAX, 0));
    send_item(OP_UPDATE, make_item(3, 1, '1, 3, '0, 0));
    drain_results();

    // full-scale coefficients: drive a row deeply negative, then clip both ways
    write_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    for (int a = 0; a < 5; a++) send_item(OP_UPDATE, make_item(7, a, REWARD_MIN, 8, '0, 0));
    send_item(OP_UPDATE, make_item(9, 0, REWARD_MIN, 7, '0, 0));
    send_item(OP_UPDATE, make_item(9, 1, REWARD_MAX, 0, '0, 0));
    send_item(OP_SELECT, make_item(9, 0, '0, 0, DRAW_MAX, 0));
    send_item(OP_SELECT, make_item(7, 0, '0, 0, DRAW_MAX, 0));
    drain_results();

    write_settings(LEARNING_RATE_RST, DISCOUNT_RST, EXPLORE_FLOOR_RST, EXPLORE_DECAY_RST);
    run_random(ITEMS_PER_PHASE, 0, 0, 1'b0);
    write_settings('0, '0, 16'd20000, 16'd60000);
    run_random(ITEMS_PER_PHASE, 80, 0, 1'b0);
    write_settings(16'd32768, COEF_MAX, 16'd16000, COEF_MAX);
    run_random(ITEMS_PER_PHASE, 0, 80, 1'b1);
    write_settings(COEF_MAX, 16'd32768, 16'd12000, 16'd64000);
    run_random(ITEMS_PER_PHASE, 35, 35, 1'b0);
    write_settings(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                   COEF_W'($urandom()));
    run_random(ITEMS_PER_PHASE, 0, 0, 1'b0);
    // zero decay and floor: the rate collapses and stays at zero
    write_settings(LEARNING_RATE_RST, DISCOUNT_RST, '0, '0);
    run_random(ITEMS_PER_PHASE, 35, 35, 1'b0);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
